>>> rtl/nsfc_pkg.sv
// Shared types and constants for the NMEA sentence framer/checker.
// No dependencies; used by every module under rtl.
package nsfc_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [7:0] START_RESET = 8'h24;
  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  localparam logic [23:0] CODE_RMC = 24'h524D43;
  localparam logic [23:0] CODE_GGA = 24'h474741;

  localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
  localparam logic [1:0] TYPE_RMC = 2'd1;
  localparam logic [1:0] TYPE_GGA = 2'd2;

  // classified input word
  typedef struct packed {
    logic       is_start;
    logic       is_cr;
    logic       is_star;
    logic       is_comma;
    logic       is_hex;
    logic [3:0] digit;
    logic [7:0] data;
  } token_t;

  typedef struct packed {
    logic [1:0] sentence_type;
    logic       checksum_present;
    logic       sentence_valid;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic       received_overflow;
  } result_t;

endpackage

>>> rtl/nmea_sentence_framer_checker_unit.sv
// Top level: NMEA sentence framer and checksum checker, one word per cycle unless full.
// A closing word passes through the token queue, then its result is registered in nsfc_back.
// Throughput: one word per cycle unless full; a 4-word token queue absorbs result stalls.
// Reset: synchronous active-high rst empties the queue and result, start character to '$'.
// Depends on nsfc_pkg, nsfc_front, nsfc_queue, nsfc_back.
module nmea_sentence_framer_checker_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] sentence_type,
  output logic       checksum_present,
  output logic       sentence_valid,
  output logic [7:0] computed_checksum,
  output logic [7:0] received_checksum,
  output logic       received_overflow
);

  nsfc_pkg::token_t  in_tok;
  nsfc_pkg::token_t  q_tok;
  nsfc_pkg::result_t res;
  logic              q_valid;
  logic              q_pop;
  logic              res_valid;

  nsfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .rx_byte   (rx_byte),
    .tok       (in_tok)
  );

  nsfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push && !full),
    .wr_tok   (in_tok),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_tok   (q_tok)
  );

  nsfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok       (q_tok),
    .tok_pop   (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop && !empty)
  );

  assign empty = !res_valid;
  assign sentence_type = res.sentence_type;
  assign checksum_present = res.checksum_present;
  assign sentence_valid = res.sentence_valid;
  assign computed_checksum = res.computed_checksum;
  assign received_checksum = res.received_checksum;
  assign received_overflow = res.received_overflow;

  a_no_star_fields: assert property (@(posedge clk) disable iff (rst)
    !empty && !checksum_present |->
      sentence_valid && received_checksum == 8'd0 && !received_overflow)
    else $error("result without checksum has inconsistent fields");

  a_overflow_fails: assert property (@(posedge clk) disable iff (rst)
    !empty && received_overflow |-> !sentence_valid && checksum_present)
    else $error("overflowed checksum reported valid");

  a_match_valid: assert property (@(posedge clk) disable iff (rst)
    !empty && checksum_present && !received_overflow |->
      sentence_valid == (received_checksum == computed_checksum))
    else $error("valid flag disagrees with checksum compare");

  a_pop_needs_token: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("token taken from empty queue");

endmodule

>>> rtl/nsfc_front.sv
// Front end: start character register and per-byte classification.
// Depends on nsfc_pkg.
module nsfc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [7:0]      cfg_data,
  input  logic [7:0]      rx_byte,
  output nsfc_pkg::token_t tok
);

  logic [7:0] start_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= nsfc_pkg::START_RESET;
    end else if (cfg_write) begin
      start_char <= cfg_data;
    end
  end

  always_comb begin
    tok.data = rx_byte;
    tok.is_start = (rx_byte == start_char);
    tok.is_cr = !tok.is_start && (rx_byte == nsfc_pkg::CHAR_CR);
    tok.is_star = !tok.is_start && (rx_byte == nsfc_pkg::CHAR_STAR);
    tok.is_comma = !tok.is_start && (rx_byte == nsfc_pkg::CHAR_COMMA);
    tok.is_hex = 1'b0;
    tok.digit = 4'd0;
    if (!tok.is_start) begin
      if (rx_byte inside {[8'h30:8'h39]}) begin
        tok.is_hex = 1'b1;
        tok.digit = rx_byte[3:0];
      end else if (rx_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
        tok.is_hex = 1'b1;
        tok.digit = rx_byte[3:0] + 4'd9;
      end
    end
  end

endmodule

>>> rtl/nsfc_queue.sv
// Short token queue between front and back end.
// Depends on nsfc_pkg.
module nsfc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  nsfc_pkg::token_t wr_tok,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output nsfc_pkg::token_t rd_tok
);

  nsfc_pkg::token_t mem [nsfc_pkg::QDEPTH];
  logic [nsfc_pkg::QAW-1:0] wr_ptr;
  logic [nsfc_pkg::QAW-1:0] rd_ptr;
  logic [nsfc_pkg::QAW:0]   count;

  assign full = (count == (nsfc_pkg::QAW+1)'(nsfc_pkg::QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_tok = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/nsfc_back.sv
// Back end: sentence state, running XOR, hex checksum, type detect, result register.
// Depends on nsfc_pkg.
module nsfc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_valid,
  input  nsfc_pkg::token_t  tok,
  output logic              tok_pop,
  output logic              res_valid,
  output nsfc_pkg::result_t res,
  input  logic              res_pop
);

  logic        in_sentence;
  logic [7:0]  running_xor;
  logic        star_seen;
  logic [7:0]  xor_at_star;
  logic [7:0]  hex_value;
  logic        hex_overflow;
  logic        hex_active;
  logic [23:0] last_three;
  logic [1:0]  prefix_count;
  logic        comma_seen;
  logic [1:0]  type_found;

  logic             res_free;
  logic             ends;
  logic             do_emit;
  logic [7:0]       computed;
  nsfc_pkg::result_t res_next;

  assign res_free = !res_valid || res_pop;
  assign ends = tok.is_start || tok.is_cr;
  assign tok_pop = tok_valid && (!ends || res_free);
  assign do_emit = tok_pop && in_sentence && ends;

  always_comb begin
    computed = star_seen ? xor_at_star : running_xor;
    res_next.sentence_type = type_found;
    res_next.checksum_present = star_seen;
    res_next.sentence_valid = !star_seen || (!hex_overflow && hex_value == computed);
    res_next.computed_checksum = computed;
    res_next.received_checksum = star_seen ? hex_value : 8'd0;
    res_next.received_overflow = star_seen && hex_overflow;
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (do_emit) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence <= 1'b0;
      running_xor <= '0;
      star_seen <= 1'b0;
      xor_at_star <= '0;
      hex_value <= '0;
      hex_overflow <= 1'b0;
      hex_active <= 1'b0;
      last_three <= '0;
      prefix_count <= '0;
      comma_seen <= 1'b0;
      type_found <= nsfc_pkg::TYPE_UNKNOWN;
    end else if (tok_pop) begin
      if (tok.is_start) begin
        in_sentence <= 1'b1;
        running_xor <= '0;
        star_seen <= 1'b0;
        xor_at_star <= '0;
        hex_value <= '0;
        hex_overflow <= 1'b0;
        hex_active <= 1'b0;
        last_three <= {16'd0, tok.data};
        prefix_count <= 2'd1;
        comma_seen <= 1'b0;
        type_found <= nsfc_pkg::TYPE_UNKNOWN;
      end else if (in_sentence) begin
        if (tok.is_cr) begin
          in_sentence <= 1'b0;
        end else begin
          if (tok.is_star) begin
            xor_at_star <= running_xor;
            star_seen <= 1'b1;
            hex_value <= '0;
            hex_overflow <= 1'b0;
            hex_active <= 1'b1;
          end else if (hex_active) begin
            if (!tok.is_hex) begin
              hex_active <= 1'b0;
            end else begin
              if (hex_value > 8'h0F) begin
                hex_overflow <= 1'b1;
              end
              hex_value <= {hex_value[3:0], tok.digit};
            end
          end
          running_xor <= running_xor ^ tok.data;
          if (!comma_seen) begin
            if (tok.is_comma) begin
              comma_seen <= 1'b1;
              if (prefix_count == 2'd3) begin
                if (last_three == nsfc_pkg::CODE_RMC) begin
                  type_found <= nsfc_pkg::TYPE_RMC;
                end else if (last_three == nsfc_pkg::CODE_GGA) begin
                  type_found <= nsfc_pkg::TYPE_GGA;
                end else begin
                  type_found <= nsfc_pkg::TYPE_UNKNOWN;
                end
              end
            end else begin
              last_three <= {last_three[15:0], tok.data};
              if (prefix_count != 2'd3) begin
                prefix_count <= prefix_count + 2'd1;
              end
            end
          end
        end
      end
    end
  end

endmodule

>>> dv/tb_nmea_sentence_framer_checker_unit.sv
// Testbench for nmea_sentence_framer_checker_unit: a directed byte table, then random
// sentences under several start characters, results checked by table or by predictor.
// Depends on nsfc_pkg and the RTL under rtl.
module tb_nmea_sentence_framer_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 12;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 56;

  localparam nsfc_pkg::result_t NO_RES = '0;
  localparam nsfc_pkg::result_t EXP_EMPTY =
    '{nsfc_pkg::TYPE_UNKNOWN, 1'b0, 1'b1, 8'h00, 8'h00, 1'b0};
  localparam nsfc_pkg::result_t EXP_OVF =
    '{nsfc_pkg::TYPE_UNKNOWN, 1'b1, 1'b0, 8'h00, 8'hFF, 1'b1};
  localparam nsfc_pkg::result_t EXP_BARE_STAR =
    '{nsfc_pkg::TYPE_UNKNOWN, 1'b1, 1'b1, 8'h00, 8'h00, 1'b0};

  typedef struct {
    logic [7:0]        data;
    bit                typed;
    nsfc_pkg::result_t res;
  } stim_row_t;

  localparam int DIR_ROWS = 26;
  stim_row_t dir_table [DIR_ROWS] = '{
    '{8'h00, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
    '{"$", 1'b0, NO_RES}, '{nsfc_pkg::CHAR_CR, 1'b1, EXP_EMPTY},
    '{"$", 1'b0, NO_RES}, '{nsfc_pkg::CHAR_STAR, 1'b0, NO_RES},
    '{"F", 1'b0, NO_RES}, '{"F", 1'b0, NO_RES}, '{"F", 1'b0, NO_RES},
    '{nsfc_pkg::CHAR_CR, 1'b1, EXP_OVF},
    '{"$", 1'b0, NO_RES}, '{nsfc_pkg::CHAR_STAR, 1'b0, NO_RES},
    '{nsfc_pkg::CHAR_CR, 1'b1, EXP_BARE_STAR},
    '{"$", 1'b0, NO_RES}, '{"R", 1'b0, NO_RES}, '{"M", 1'b0, NO_RES},
    '{"C", 1'b0, NO_RES}, '{nsfc_pkg::CHAR_COMMA, 1'b0, NO_RES},
    '{nsfc_pkg::CHAR_STAR, 1'b0, NO_RES},
    '{"a", 1'b0, NO_RES}, '{"$", 1'b0, NO_RES},
    '{"G", 1'b0, NO_RES}, '{"G", 1'b0, NO_RES}, '{"A", 1'b0, NO_RES},
    '{nsfc_pkg::CHAR_COMMA, 1'b0, NO_RES}, '{nsfc_pkg::CHAR_CR, 1'b0, NO_RES}
  };

  localparam logic [7:0] PHASE_START [PHASES] = '{
    nsfc_pkg::START_RESET, 8'h00, 8'hFF, nsfc_pkg::CHAR_CR, nsfc_pkg::CHAR_STAR,
    nsfc_pkg::CHAR_COMMA, 8'h00, nsfc_pkg::START_RESET
  };

  localparam string FIELD_CHARS = "0123456789.,ABCDEFNSEWMKT";

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] rx_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] sentence_type;
  logic       checksum_present;
  logic       sentence_valid;
  logic [7:0] computed_checksum;
  logic [7:0] received_checksum;
  logic       received_overflow;

  nmea_sentence_framer_checker_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop),
    .sentence_type(sentence_type), .checksum_present(checksum_present),
    .sentence_valid(sentence_valid), .computed_checksum(computed_checksum),
    .received_checksum(received_checksum), .received_overflow(received_overflow)
  );

  // framer model state
  logic [7:0]  fr_start = nsfc_pkg::START_RESET;
  bit          fr_open = 1'b0;
  logic [7:0]  fr_xor = 8'h00;
  bit          fr_star = 1'b0;
  logic [7:0]  fr_xor_star = 8'h00;
  logic [7:0]  fr_hex = 8'h00;
  bit          fr_ovf = 1'b0;
  bit          fr_hex_on = 1'b0;
  logic [23:0] fr_tail = 24'h0;
  int          fr_prefix = 0;
  bit          fr_comma = 1'b0;
  logic [1:0]  fr_type = nsfc_pkg::TYPE_UNKNOWN;

  nsfc_pkg::result_t sentences_due [$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      sentences_expected = 0;
  int      sentences_checked = 0;
  int      starts_used = 0;
  bit      steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 10) return "0" + n;
    return 8'((lower ? "a" : "A") + n - 10);
  endfunction

  function automatic void frame_open();
    fr_open = 1'b1;
    fr_xor = 8'h00;
    fr_star = 1'b0;
    fr_xor_star = 8'h00;
    fr_hex = 8'h00;
    fr_ovf = 1'b0;
    fr_hex_on = 1'b0;
    fr_tail = {16'h0, fr_start};
    fr_prefix = 1;
    fr_comma = 1'b0;
    fr_type = nsfc_pkg::TYPE_UNKNOWN;
  endfunction

  function automatic nsfc_pkg::result_t frame_summary();
    nsfc_pkg::result_t r;
    r.computed_checksum = fr_star ? fr_xor_star : fr_xor;
    r.sentence_type = fr_type;
    r.checksum_present = fr_star;
    r.sentence_valid = !fr_star || (!fr_ovf && fr_hex == r.computed_checksum);
    r.received_checksum = fr_star ? fr_hex : 8'h00;
    r.received_overflow = fr_star && fr_ovf;
    return r;
  endfunction

  // returns 1 when the byte closes a sentence
  function automatic bit frame_byte(input logic [7:0] b, output nsfc_pkg::result_t r);
    int d;
    r = NO_RES;
    if (!fr_open) begin
      if (b == fr_start) frame_open();
      return 1'b0;
    end
    if (b == fr_start) begin
      r = frame_summary();
      frame_open();
      return 1'b1;
    end
    if (b == nsfc_pkg::CHAR_CR) begin
      r = frame_summary();
      fr_open = 1'b0;
      return 1'b1;
    end
    d = hex_nibble(b);
    if (b == nsfc_pkg::CHAR_STAR) begin
      fr_xor_star = fr_xor;
      fr_star = 1'b1;
      fr_hex = 8'h00;
      fr_ovf = 1'b0;
      fr_hex_on = 1'b1;
    end else if (fr_hex_on) begin
      if (d < 0) begin
        fr_hex_on = 1'b0;
      end else begin
        if (fr_hex > 8'h0F) fr_ovf = 1'b1;
        fr_hex = {fr_hex[3:0], d[3:0]};
      end
    end
    fr_xor ^= b;
    if (!fr_comma) begin
      if (b == nsfc_pkg::CHAR_COMMA) begin
        fr_comma = 1'b1;
        if (fr_prefix >= 3) begin
          if (fr_tail == nsfc_pkg::CODE_RMC) fr_type = nsfc_pkg::TYPE_RMC;
          else if (fr_tail == nsfc_pkg::CODE_GGA) fr_type = nsfc_pkg::TYPE_GGA;
          else fr_type = nsfc_pkg::TYPE_UNKNOWN;
        end
      end else begin
        fr_tail = {fr_tail[15:0], b};
        if (fr_prefix < 3) fr_prefix++;
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void due_add(input nsfc_pkg::result_t r);
    sentences_due = {sentences_due, r};
  endfunction

  task automatic send_word(input logic [7:0] b, input bit typed,
                           input nsfc_pkg::result_t typed_res);
    int                gap;
    bit                closes;
    nsfc_pkg::result_t pred;
    gap = steady ? 0 : int'($urandom_range(0, 4));
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    bytes_sent++;
    closes = frame_byte(b, pred);
    if (closes || typed) begin
      due_add(typed ? typed_res : pred);
      sentences_expected++;
    end
  endtask

  // stop sending and wait out every outstanding sentence
  task automatic settle();
    push <= 1'b0;
    while (sentences_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(input logic [7:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    fr_start = v;
    starts_used++;
  endtask

  task automatic send_random_sentence();
    logic [7:0] words [$];
    logic [7:0] body [$];
    logic [7:0] c;
    logic [7:0] sum;
    logic [7:0] junk;
    int         mode;
    bit         lower;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) words = {words, 8'($urandom_range(0, 255))};
    end else begin
      case ($urandom_range(0, 5))
        0: body = {"G", "P", "R", "M", "C", nsfc_pkg::CHAR_COMMA};
        1: body = {"G", "N", "G", "G", "A", nsfc_pkg::CHAR_COMMA};
        2: body = {"R", "M", "C", nsfc_pkg::CHAR_COMMA};
        3: body = {"G", "G", "A", nsfc_pkg::CHAR_COMMA};
        4: begin
          repeat ($urandom_range(0, 2)) body = {body, 8'($urandom_range("A", "Z"))};
          body = {body, nsfc_pkg::CHAR_COMMA};
        end
        default: begin
          repeat ($urandom_range(3, 6)) body = {body, 8'($urandom_range("A", "Z"))};
        end
      endcase
      repeat ($urandom_range(0, 10)) begin
        c = FIELD_CHARS[$urandom_range(0, FIELD_CHARS.len() - 1)];
        if ($urandom_range(0, 15) == 0) c = 8'($urandom_range(0, 255));
        if (c != fr_start && c != nsfc_pkg::CHAR_CR) body = {body, c};
      end
      mode = int'($urandom_range(0, 6));
      lower = 1'($urandom_range(0, 1));
      sum = 8'h00;
      if (mode == 6) begin
        body = {body, nsfc_pkg::CHAR_STAR};
        body = {body, hex_char(4'($urandom_range(0, 15)), lower)};
        body = {body, hex_char(4'($urandom_range(0, 15)), lower)};
      end
      foreach (body[i]) sum ^= body[i];
      words = {words, fr_start};
      words = {words, body};
      if (mode != 0) words = {words, nsfc_pkg::CHAR_STAR};
      if (mode == 3) sum ^= 8'($urandom_range(1, 255));
      if (mode == 4) words = {words, hex_char(4'($urandom_range(1, 15)), lower)};
      if (mode != 0 && mode != 5) begin
        words = {words, hex_char(sum[7:4], lower)};
        words = {words, hex_char(sum[3:0], lower)};
      end
      if ($urandom_range(0, 3) == 0) begin
        junk = 8'($urandom_range(0, 255));
        if (junk != fr_start && junk != nsfc_pkg::CHAR_CR) words = {words, junk};
      end
      if ($urandom_range(0, 4) != 0) words = {words, nsfc_pkg::CHAR_CR};
    end
    foreach (words[i]) send_word(words[i], 1'b0, NO_RES);
  endtask

  // result side: random pop gaps unless steady, check each popped result
  initial begin
    int                gap;
    nsfc_pkg::result_t want;
    while (rst) @(posedge clk);
    forever begin
      gap = steady ? 0 : int'($urandom_range(0, 4));
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (sentences_due.size() == 0) begin
        report_mismatch("unexpected result, checksum", int'(computed_checksum), 0);
      end else begin
        want = sentences_due.pop_front();
        sentences_checked++;
        if (sentence_type !== want.sentence_type)
          report_mismatch("sentence_type", int'(sentence_type),
                          int'(want.sentence_type));
        if (checksum_present !== want.checksum_present)
          report_mismatch("checksum_present", int'(checksum_present),
                          int'(want.checksum_present));
        if (sentence_valid !== want.sentence_valid)
          report_mismatch("sentence_valid", int'(sentence_valid),
                          int'(want.sentence_valid));
        if (computed_checksum !== want.computed_checksum)
          report_mismatch("computed_checksum", int'(computed_checksum),
                          int'(want.computed_checksum));
        if (received_checksum !== want.received_checksum)
          report_mismatch("received_checksum", int'(received_checksum),
                          int'(want.received_checksum));
        if (received_overflow !== want.received_overflow)
          report_mismatch("received_overflow", int'(received_overflow),
                          int'(want.received_overflow));
      end
    end
  end

  initial begin
    int         phase_base;
    logic [7:0] sc;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) send_word(dir_table[i].data, dir_table[i].typed, dir_table[i].res);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      sc = (p == 6) ? 8'($urandom_range(0, 255)) : PHASE_START[p];
      write_start(sc);
      steady = (p % 3 == 1);
      phase_base = bytes_sent;
      while (bytes_sent - phase_base < PHASE_BYTES) send_random_sentence();
      settle();
    end

    $display("run covered %0d bytes and %0d checked sentences over %0d start settings",
             bytes_sent, sentences_checked, starts_used + 1);
    $display("start characters included 00, FF, CR, '*', ',' and one random value");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/nsfc_pkg.sv
rtl/nsfc_front.sv
rtl/nsfc_queue.sv
rtl/nsfc_back.sv
rtl/nmea_sentence_framer_checker_unit.sv
dv/tb_nmea_sentence_framer_checker_unit.sv
